>>> rtl/ost_pkg.sv
// Shared types and constants for the online suffix tree builder.
// No dependencies; imported by ost_child_store, online_suffix_tree_builder and the testbench.
package ost_pkg;

  localparam int MAX_TEXT     = 1024;
  localparam int NODE_CAP     = 2 * MAX_TEXT;
  localparam int POS_W        = 10;
  localparam int LEN_W        = 11;
  localparam int NODE_W       = 11;
  localparam int CNT_W        = 12;
  localparam int SYM_W        = 8;
  localparam int ALPHABET_DEF = 256;
  localparam int EPOCH_W      = 8;

  localparam logic [LEN_W-1:0] OPEN_END = LEN_W'(MAX_TEXT);

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] node_index;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  text_length;
    logic [CNT_W-1:0]  node_count;
    logic [LEN_W-1:0]  pending_suffixes;
    logic [NODE_W-1:0] pt_node;
    logic [POS_W-1:0]  pt_edge;
    logic [LEN_W-1:0]  pt_len;
    logic [NODE_W-1:0] child;
    logic [POS_W-1:0]  edge_start;
    logic [LEN_W-1:0]  edge_end;
    logic [NODE_W-1:0] link_node;
    logic              full_res;
  } result_t;

  // Child table access from the sequencer
  typedef struct packed {
    logic              restart;
    logic              rd_en;
    logic [NODE_W-1:0] rd_node;
    logic [SYM_W-1:0]  rd_sym;
    logic              wr_en;
    logic [NODE_W-1:0] wr_node;
    logic [SYM_W-1:0]  wr_sym;
    logic [NODE_W-1:0] wr_child;
  } child_req_t;

endpackage

>>> rtl/ost_child_store.sv
// Child table of the suffix tree: one row per node, one entry per symbol.
// Entries carry an epoch tag so a restart empties every row at once.
// Depends on ost_pkg.
module ost_child_store import ost_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  child_req_t        req,
  output logic [NODE_W-1:0] rd_data,
  output logic              ready
);

  localparam int AW    = NODE_W + $clog2(ALPHABET);
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(ALPHABET);

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [NODE_W-1:0]  kid;
  } entry_t;

  entry_t             mem [DEPTH];
  entry_t             q;
  logic [EPOCH_W-1:0] epoch;
  logic               sweeping;
  logic [AW-1:0]      sweep_addr;

  // Write port: the sweep has priority, then sequencer writes
  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_addr] <= '0;
    end else if (req.wr_en) begin
      mem[{req.wr_node, req.wr_sym[SW-1:0]}] <= '{tag: epoch, kid: req.wr_child};
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      q <= mem[{req.rd_node, req.rd_sym[SW-1:0]}];
    end
  end

  // Advance the epoch on restart; sweep all tags when it wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      epoch      <= EPOCH_W'(1);
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + AW'(1);
      if (sweep_addr == {AW{1'b1}}) begin
        sweeping <= 1'b0;
      end
    end else if (req.restart) begin
      if (epoch == {EPOCH_W{1'b1}}) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
        epoch      <= EPOCH_W'(1);
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

  assign rd_data = (q.tag == epoch) ? q.kid : '0;
  assign ready   = !sweeping;

endmodule

>>> rtl/online_suffix_tree_builder.sv
// Online suffix tree builder: Ukkonen construction over block memories.
// Depends on ost_pkg and ost_child_store.
//
// One command per transaction: restart empties the tree, append adds one byte
// when the text is not full and the symbol is in the alphabet, read returns a
// node's child, edge bounds and suffix link. Each transaction yields exactly
// one result. A read goes from the accepting cycle through a wait on the child
// and node stores to the state that loads the result; a restart, an unused
// command or a refused append goes straight there. An append runs the insertion
// loop, whose passes walk down an edge, add a leaf (and may then follow a suffix
// link), split an edge (likewise), or end on the final match; passes amortize to
// a small constant per symbol. The length of a pass is set by the dependent
// registered reads of the text, child and edge memories. A stalled result holds
// the block in its last state. After reset, and on every 255th restart, the
// child table is cleared by a sweep over all 2048 times ALPHABET (rounded up to
// a power of two) entries, during which no transaction is taken.
module online_suffix_tree_builder import ost_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ_WAIT, S_SYM, S_SYM_WAIT, S_CHILD_WAIT, S_NODE_WAIT,
    S_CMP_WAIT, S_SPLIT2, S_SPLIT3, S_STEP_END, S_LINK, S_LINK_WAIT, S_DONE
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  text_count;
  logic [CNT_W-1:0]  nodes_used;
  logic [LEN_W-1:0]  pending;
  logic [NODE_W-1:0] pnode;
  logic [LEN_W-1:0]  pedge;
  logic [LEN_W-1:0]  plen;
  logic [NODE_W-1:0] link_wait;
  logic [SYM_W-1:0]  cur_sym;
  logic [POS_W-1:0]  pos;
  logic [SYM_W-1:0]  edge_sym;
  logic [NODE_W-1:0] nx;
  logic [POS_W-1:0]  nx_start;
  logic [NODE_W-1:0] split;
  logic [SYM_W-1:0]  split_sym;
  logic [NODE_W-1:0] target;
  logic [NODE_W-1:0] rd_kid;
  logic [POS_W-1:0]  rd_es;
  logic [LEN_W-1:0]  rd_ee;
  logic [NODE_W-1:0] rd_sl;
  logic              rd_hit;
  logic              rd_sym_ok;
  logic [NODE_W-1:0] rd_node;
  logic              full;

  // Memories
  logic [SYM_W-1:0]  text_mem [MAX_TEXT];
  logic [POS_W-1:0]  es_mem   [NODE_CAP];
  logic [LEN_W-1:0]  ee_mem   [NODE_CAP];
  logic [NODE_W-1:0] ln_mem   [NODE_CAP];
  logic [SYM_W-1:0]  text_q;
  logic [POS_W-1:0]  es_q;
  logic [LEN_W-1:0]  ee_q;
  logic [NODE_W-1:0] ln_q;

  logic              t_we;
  logic [POS_W-1:0]  t_wa;
  logic [POS_W-1:0]  t_ra;
  logic              es_we, ee_we, ln_we;
  logic [NODE_W-1:0] es_wa, ee_wa, ln_wa;
  logic [POS_W-1:0]  es_wd;
  logic [LEN_W-1:0]  ee_wd;
  logic [NODE_W-1:0] ln_wd;
  logic [NODE_W-1:0] nr_addr;

  child_req_t        creq;
  logic [NODE_W-1:0] child_q;
  logic              cs_ready;

  logic              accept;
  logic              sym_ok;
  logic [LEN_W-1:0]  edge_pos;
  logic [LEN_W-1:0]  span_end;
  logic [LEN_W-1:0]  span;
  logic [LEN_W-1:0]  cmp_pos;
  logic [LEN_W-1:0]  split_end;
  logic [LEN_W-1:0]  pend_dec;
  logic [NODE_W-1:0] nu_id;

  assign item_stall = (state != S_IDLE) || !cs_ready;
  assign accept     = item_valid && !item_stall;
  assign sym_ok     = ({1'b0, item.symbol} < (SYM_W + 1)'(ALPHABET));
  assign nu_id      = nodes_used[NODE_W-1:0];
  assign edge_pos   = (plen == '0) ? {1'b0, pos} : pedge;
  assign span_end   = (ee_q < text_count) ? ee_q : text_count;
  assign span       = (span_end >= {1'b0, es_q}) ? span_end - {1'b0, es_q} : '0;
  assign cmp_pos    = {1'b0, es_q} + plen;
  assign split_end  = {1'b0, nx_start} + plen;
  assign pend_dec   = pending - LEN_W'(1);

  ost_child_store #(.ALPHABET(ALPHABET)) u_child (
    .clk     (clk),
    .rst     (rst),
    .req     (creq),
    .rd_data (child_q),
    .ready   (cs_ready)
  );

  // Memory ports driven by the sequencer
  always_comb begin
    t_we    = 1'b0;
    t_wa    = pos;
    t_ra    = edge_pos[POS_W-1:0];
    es_we   = 1'b0;
    ee_we   = 1'b0;
    ln_we   = 1'b0;
    es_wa   = nu_id;
    ee_wa   = nu_id;
    ln_wa   = nu_id;
    es_wd   = pos;
    ee_wd   = OPEN_END;
    ln_wd   = '0;
    nr_addr = nx;
    creq    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd_t'(item.command) == CMD_RESTART) begin
          creq.restart = 1'b1;
        end
        if (accept && cmd_t'(item.command) == CMD_APPEND &&
            text_count < LEN_W'(MAX_TEXT) && sym_ok) begin
          t_we = 1'b1;
          t_wa = text_count[POS_W-1:0];
        end
        nr_addr      = item.node_index;
        creq.rd_en   = accept && cmd_t'(item.command) == CMD_READ;
        creq.rd_node = item.node_index;
        creq.rd_sym  = item.symbol;
      end
      S_SYM_WAIT: begin
        creq.rd_en   = 1'b1;
        creq.rd_node = pnode;
        creq.rd_sym  = text_q;
      end
      S_CHILD_WAIT: begin
        nr_addr = child_q;
        if (child_q == '0) begin
          es_we         = 1'b1;
          ee_we         = 1'b1;
          ln_we         = 1'b1;
          creq.wr_en    = 1'b1;
          creq.wr_node  = pnode;
          creq.wr_sym   = edge_sym;
          creq.wr_child = nu_id;
        end
      end
      S_NODE_WAIT: begin
        t_ra = cmp_pos[POS_W-1:0];
      end
      S_CMP_WAIT: begin
        if (text_q == cur_sym) begin
          ln_we = (link_wait != '0);
          ln_wa = link_wait;
          ln_wd = pnode;
        end else begin
          es_we         = 1'b1;
          ee_we         = 1'b1;
          ln_we         = 1'b1;
          es_wd         = nx_start;
          ee_wd         = split_end;
          creq.wr_en    = 1'b1;
          creq.wr_node  = pnode;
          creq.wr_sym   = edge_sym;
          creq.wr_child = nu_id;
        end
      end
      S_SPLIT2: begin
        es_we         = 1'b1;
        ee_we         = 1'b1;
        ln_we         = 1'b1;
        creq.wr_en    = 1'b1;
        creq.wr_node  = split;
        creq.wr_sym   = cur_sym;
        creq.wr_child = nu_id;
      end
      S_SPLIT3: begin
        es_we         = 1'b1;
        es_wa         = nx;
        es_wd         = split_end[POS_W-1:0];
        creq.wr_en    = 1'b1;
        creq.wr_node  = split;
        creq.wr_sym   = split_sym;
        creq.wr_child = nx;
      end
      S_STEP_END: begin
        ln_we = (link_wait != '0);
        ln_wa = link_wait;
        ln_wd = target;
      end
      S_LINK: begin
        nr_addr = pnode;
      end
      default: begin
      end
    endcase
  end

  // Text store
  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_wa] <= item.symbol;
    end
    text_q <= text_mem[t_ra];
  end

  // Node stores: edge start, edge end, suffix link
  always_ff @(posedge clk) begin
    if (es_we) es_mem[es_wa] <= es_wd;
    if (ee_we) ee_mem[ee_wa] <= ee_wd;
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    es_q <= es_mem[nr_addr];
    ee_q <= ee_mem[nr_addr];
    ln_q <= ln_mem[nr_addr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      text_count   <= '0;
      nodes_used   <= CNT_W'(1);
      pending      <= '0;
      pnode        <= '0;
      pedge        <= '0;
      plen         <= '0;
      link_wait    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_sym   <= item.symbol;
            full      <= 1'b0;
            rd_kid    <= '0;
            rd_es     <= '0;
            rd_ee     <= '0;
            rd_sl     <= '0;
            rd_hit    <= ({1'b0, item.node_index} < nodes_used);
            rd_sym_ok <= sym_ok;
            state     <= S_DONE;
            unique case (cmd_t'(item.command))
              CMD_RESTART: begin
                text_count <= '0;
                nodes_used <= CNT_W'(1);
                pending    <= '0;
                pnode      <= '0;
                pedge      <= '0;
                plen       <= '0;
                link_wait  <= '0;
              end
              CMD_APPEND: begin
                if (text_count >= LEN_W'(MAX_TEXT)) begin
                  full <= 1'b1;
                end else if (sym_ok) begin
                  pos        <= text_count[POS_W-1:0];
                  text_count <= text_count + LEN_W'(1);
                  link_wait  <= '0;
                  pending    <= pending + LEN_W'(1);
                  state      <= S_SYM;
                end
              end
              CMD_READ: begin
                state <= S_READ_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ_WAIT: begin
          if (rd_hit) begin
            rd_kid <= rd_sym_ok ? child_q : '0;
          end
          state <= S_DONE;
        end
        S_SYM: begin
          pedge <= edge_pos;
          state <= S_SYM_WAIT;
        end
        S_SYM_WAIT: begin
          edge_sym <= text_q;
          state    <= S_CHILD_WAIT;
        end
        S_CHILD_WAIT: begin
          nx <= child_q;
          if (child_q == '0) begin
            nodes_used <= nodes_used + CNT_W'(1);
            target     <= pnode;
            state      <= S_STEP_END;
          end else begin
            state <= S_NODE_WAIT;
          end
        end
        S_NODE_WAIT: begin
          nx_start <= es_q;
          if (plen >= span) begin
            pedge <= pedge + span;
            plen  <= plen - span;
            pnode <= nx;
            state <= S_SYM;
          end else begin
            state <= S_CMP_WAIT;
          end
        end
        S_CMP_WAIT: begin
          if (text_q == cur_sym) begin
            plen      <= plen + LEN_W'(1);
            link_wait <= pnode;
            state     <= S_DONE;
          end else begin
            split      <= nu_id;
            split_sym  <= text_q;
            nodes_used <= nodes_used + CNT_W'(1);
            state      <= S_SPLIT2;
          end
        end
        S_SPLIT2: begin
          nodes_used <= nodes_used + CNT_W'(1);
          state      <= S_SPLIT3;
        end
        S_SPLIT3: begin
          target <= split;
          state  <= S_STEP_END;
        end
        S_STEP_END: begin
          link_wait <= target;
          pending   <= pend_dec;
          if (pnode == '0 && plen != '0) begin
            plen  <= plen - LEN_W'(1);
            pedge <= {1'b0, pos} + LEN_W'(1) - pend_dec;
            state <= (pend_dec != '0) ? S_SYM : S_DONE;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          state <= S_LINK_WAIT;
        end
        S_LINK_WAIT: begin
          pnode <= (pnode == '0) ? '0 : ln_q;
          state <= (pending != '0) ? S_SYM : S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid            <= 1'b1;
            result.text_length      <= text_count;
            result.node_count       <= nodes_used;
            result.pending_suffixes <= pending;
            result.pt_node          <= pnode;
            result.pt_edge          <= pedge[POS_W-1:0];
            result.pt_len           <= plen;
            result.child            <= rd_kid;
            result.edge_start       <= rd_es;
            result.edge_end         <= rd_ee;
            result.link_node        <= rd_sl;
            result.full_res         <= full;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Edge bounds and link of a read; the root always reads as zero
      if (state == S_READ_WAIT && rd_hit && rd_node != '0) begin
        rd_es <= es_q;
        rd_ee <= ee_q;
        rd_sl <= ln_q;
      end
    end
  end

  // Node addressed by the read in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_node <= item.node_index;
    end
  end

endmodule

>>> tb/online_suffix_tree_builder_checker.sv
// Checker for the online suffix tree builder: keeps its own suffix tree,
// predicts the result of every command transaction and compares it. Uses ost_pkg.
module online_suffix_tree_builder_checker import ost_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fails,
  output int      waiting
);

  localparam int SYMS = 256;

  // Predicted tree
  logic [7:0]        sym_mem [MAX_TEXT];
  logic [NODE_W-1:0] kid_mem [NODE_CAP*SYMS];
  int unsigned       estart [NODE_CAP];
  int unsigned       eend [NODE_CAP];
  int unsigned       slink [NODE_CAP];
  int unsigned       tlen, ncount, npend, anode, aedge, alen, link_pend;

  result_t expected_results[$];

  function automatic int unsigned char_at(int unsigned pos);
    return pos < MAX_TEXT ? int'(sym_mem[pos]) : 0;
  endfunction

  function automatic int unsigned alloc_node(int unsigned first, int unsigned last);
    int unsigned id;
    id = ncount;
    if (id >= NODE_CAP) return 0;
    estart[id] = first;
    eend[id] = last;
    slink[id] = 0;
    for (int s = 0; s < SYMS; s++) kid_mem[id*SYMS+s] = '0;
    ncount = id + 1;
    return id;
  endfunction

  function automatic int unsigned edge_span(int unsigned n);
    int unsigned e;
    e = eend[n] < tlen ? eend[n] : tlen;
    return e >= estart[n] ? e - estart[n] : 0;
  endfunction

  function automatic void set_link(int unsigned n);
    if (link_pend > 0 && link_pend < NODE_CAP) slink[link_pend] = n;
    link_pend = n;
  endfunction

  function automatic void clear_tree();
    tlen = 0; npend = 0; anode = 0; aedge = 0; alen = 0; link_pend = 0;
    ncount = 1;
    estart[0] = 0; eend[0] = 0; slink[0] = 0;
    for (int s = 0; s < SYMS; s++) kid_mem[s] = '0;
  endfunction

  // Ukkonen extension by one symbol
  function automatic void extend_text(int unsigned sym);
    int unsigned pos, c, nx, len, split, leaf;
    pos = tlen;
    sym_mem[pos] = sym[7:0];
    tlen = pos + 1;
    link_pend = 0;
    npend++;
    while (npend > 0) begin
      if (alen == 0) aedge = pos;
      c = char_at(aedge) % SYMS;
      nx = kid_mem[anode*SYMS+c];
      if (nx == 0) begin
        leaf = alloc_node(pos, MAX_TEXT);
        kid_mem[anode*SYMS+c] = NODE_W'(leaf);
        set_link(anode);
      end else begin
        len = edge_span(nx);
        // walk down a whole edge
        if (alen >= len) begin
          aedge += len;
          alen -= len;
          anode = nx;
          continue;
        end
        // symbol already present: stay implicit
        if (char_at(estart[nx] + alen) == sym) begin
          alen++;
          set_link(anode);
          break;
        end
        split = alloc_node(estart[nx], estart[nx] + alen);
        kid_mem[anode*SYMS+c] = NODE_W'(split);
        leaf = alloc_node(pos, MAX_TEXT);
        kid_mem[split*SYMS+sym] = NODE_W'(leaf);
        estart[nx] += alen;
        kid_mem[split*SYMS+(char_at(estart[nx]) % SYMS)] = NODE_W'(nx);
        set_link(split);
      end
      npend--;
      if (anode == 0 && alen > 0) begin
        alen--;
        aedge = pos + 1 - npend;
      end else begin
        anode = slink[anode] < NODE_CAP ? slink[anode] : 0;
      end
    end
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    int unsigned idx;
    r = '0;
    idx = it.node_index;
    case (cmd_t'(it.command))
      CMD_RESTART: clear_tree();
      CMD_APPEND: begin
        if (tlen >= MAX_TEXT) r.full_res = 1'b1;
        else extend_text(it.symbol);
      end
      CMD_READ: begin
        if (idx < ncount && idx < NODE_CAP) begin
          r.child = kid_mem[idx*SYMS+it.symbol];
          r.edge_start = estart[idx][POS_W-1:0];
          r.edge_end = eend[idx][LEN_W-1:0];
          r.link_node = slink[idx][NODE_W-1:0];
        end
      end
      default: ;
    endcase
    r.text_length = tlen[LEN_W-1:0];
    r.node_count = ncount[CNT_W-1:0];
    r.pending_suffixes = npend[LEN_W-1:0];
    r.pt_node = anode[NODE_W-1:0];
    r.pt_edge = aedge[POS_W-1:0];
    r.pt_len = alen[LEN_W-1:0];
    return r;
  endfunction

  assign waiting = expected_results.size();

  // Predict on each accepted command, compare each accepted result
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      clear_tree();
      expected_results.delete();
      fails <= 0;
    end else begin
      if (item_valid && !item_stall) expected_results.push_back(predict_result(item));
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          if (fails < 10) $display("unexpected result transaction: %p", result);
          fails <= fails + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.text_length !== exp_r.text_length ||
              result.node_count !== exp_r.node_count ||
              result.pending_suffixes !== exp_r.pending_suffixes ||
              result.pt_node !== exp_r.pt_node ||
              result.pt_edge !== exp_r.pt_edge ||
              result.pt_len !== exp_r.pt_len ||
              result.child !== exp_r.child ||
              result.edge_start !== exp_r.edge_start ||
              result.edge_end !== exp_r.edge_end ||
              result.link_node !== exp_r.link_node ||
              result.full_res !== exp_r.full_res) begin
            if (fails < 10) $display("mismatch\n  expected %p\n  actual   %p", exp_r, result);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/online_suffix_tree_builder_test.sv
// Testbench top for the online suffix tree builder: drives command transactions
// with random idling and stalls. Depends on ost_pkg, the block and its checker.
module online_suffix_tree_builder_test import ost_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2500000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      fails, waiting;
  int      send_idle = 0, recv_stall = 0;
  int      quiet_cycles = 0;
  int      sent = 0;
  int      appends = 0;
  int      sym_base = 0, sym_span = 2;

  online_suffix_tree_builder i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  online_suffix_tree_builder_checker i_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fails(fails), .waiting(waiting)
  );

  always #6 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < recv_stall);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Cycle through idling modes as the run advances
  function automatic void pick_idling(int n);
    case ((n / 200) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 49; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 49; end
      default: begin send_idle = 22; recv_stall = 22; end
    endcase
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(cmd_t cmd, int sym, int idx);
    pick_idling(sent);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= '{command: cmd, symbol: sym[SYM_W-1:0], node_index: idx[NODE_W-1:0]};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    sent++;
    if (cmd == CMD_RESTART) appends = 0;
    if (cmd == CMD_APPEND) appends++;
  endtask

  // Restart with a fresh symbol window: narrow windows give deep trees
  task automatic restart_tree();
    int spans[4] = '{2, 3, 4, 256};
    sym_span = spans[$urandom_range(3)];
    sym_base = $urandom_range(0, 256 - sym_span);
    send(CMD_RESTART, $urandom_range(255), $urandom_range(2047));
  endtask

  task automatic random_item(bit fill);
    int r, sym, idx;
    r = $urandom_range(99);
    sym = sym_base + $urandom_range(sym_span - 1);
    idx = ($urandom_range(9) == 0) ? $urandom_range(2047)
        : $urandom_range(0, (2 * appends + 1 < 2047) ? 2 * appends + 1 : 2047);
    if (!fill && r < 3) restart_tree();
    else if (r < 4) send(CMD_NONE, $urandom_range(255), $urandom_range(2047));
    else if (r < (fill ? 10 : 30)) begin
      if ($urandom_range(9) == 0) sym = $urandom_range(255);
      send(CMD_READ, sym, idx);
    end else send(CMD_APPEND, sym, idx);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every command, repeats that split and link
    send(CMD_RESTART, 0, 0);
    send(CMD_READ, 0, 0);
    send(CMD_APPEND, 8'hff, 2047);
    send(CMD_APPEND, 0, 0);
    send(CMD_APPEND, 8'hff, 0);
    send(CMD_APPEND, 0, 0);
    send(CMD_APPEND, 8'h5a, 0);
    send(CMD_APPEND, 8'hff, 0);
    send(CMD_APPEND, 0, 0);
    send(CMD_APPEND, 8'hff, 0);
    send(CMD_APPEND, 8'ha5, 0);
    send(CMD_READ, 8'hff, 0);
    send(CMD_READ, 0, 0);
    send(CMD_READ, 8'h5a, 1);
    send(CMD_READ, 0, 3);
    send(CMD_READ, 8'hff, 5);
    send(CMD_READ, 8'hff, 2047);
    send(CMD_NONE, 8'hff, 2047);
    send(CMD_RESTART, 8'hff, 2047);
    send(CMD_APPEND, 7, 0);
    send(CMD_APPEND, 7, 0);
    send(CMD_APPEND, 7, 0);
    send(CMD_READ, 7, 0);
    send(CMD_READ, 0, 1);

    // Fill one tree past capacity, with reads mixed in
    restart_tree();
    while (appends < MAX_TEXT + 12) random_item(1'b1);
    send(CMD_READ, sym_base, 0);

    // Mixed random traffic with restarts
    restart_tree();
    while (sent < 1450) random_item(1'b0);

    @(negedge clk);
    item_valid <= 1'b0;
    wait (waiting == 0);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
rtl/ost_pkg.sv
rtl/ost_child_store.sv
rtl/online_suffix_tree_builder.sv
tb/online_suffix_tree_builder_checker.sv
tb/online_suffix_tree_builder_test.sv
